[sv/bdac_pkg.sv]
// Shared types, constants and helpers for the binary to decimal ASCII unit.
// No dependencies; imported by every module of the block.
package bdac_pkg;

    // Width of the binary number that gets converted
    localparam int VALUE_BITS = 16;

    // Input tdata width: value padded to whole bytes
    localparam int S_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8;

    // One BCD digit and one ASCII character
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 6;
    localparam int M_TDATA_W  = ((CHAR_W + 7) / 8) * 8;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    // Count decimal digits of the largest VALUE_BITS-bit number
    function automatic int dec_digits(input int bits);
        longint unsigned v;
        int              n;
        v = (64'd1 << bits) - 64'd1;
        n = 0;
        for (int i = 0; i < 20; i++) begin
            if (v != 0) begin
                v = v / 10;
                n = n + 1;
            end
        end
        return n;
    endfunction

    localparam int DIGITS  = dec_digits(VALUE_BITS);
    localparam int BCD_W   = DIGITS * DIGIT_W;
    localparam int CNT_W   = $clog2(DIGITS + 1);
    localparam int IDX_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int STEP_W  = $clog2(VALUE_BITS);

    // Queue between converter and emitter
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // One converted number: packed BCD digits and significant digit count
    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [CNT_W-1:0] ndig;
    } entry_t;

    // Add 3 to every BCD digit of 5 or more (double-dabble correction)
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] r;
        r = b;
        for (int i = 0; i < DIGITS; i++) begin
            if (b[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                r[i*DIGIT_W +: DIGIT_W] = b[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end
        end
        return r;
    endfunction

endpackage

[sv/bdac_front.sv]
// Front end: accepts a binary number and converts it to BCD by shift-add-3.
// Depends on bdac_pkg; feeds bdac_queue.
module bdac_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bdac_pkg::S_TDATA_W-1:0] s_tdata,   // [VALUE_BITS-1:0] value
    output logic                        push_valid,
    input  logic                        push_ready,
    output bdac_pkg::entry_t            push_entry
);
    import bdac_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_BITS-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [BCD_W-1:0]       bcd_adj;
    logic [CNT_W-1:0]       ndig;

    // Correct digits before each shift
    assign bcd_adj = bcd_adjust(bcd_reg);

    // Find the highest nonzero digit; zero still shows one digit
    always_comb begin
        ndig = CNT_W'(1);
        for (int i = 1; i < DIGITS; i++) begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] != '0) begin
                ndig = CNT_W'(i + 1);
            end
        end
    end

    assign s_tready         = (state_reg == ST_IDLE);
    assign push_valid       = (state_reg == ST_DONE);
    assign push_entry.bcd   = bcd_reg;
    assign push_entry.ndig  = ndig;

    // Sequence load, conversion steps and hand-off
    always_comb begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    bin_next   = s_tdata[VALUE_BITS-1:0];
                    bcd_next   = '0;
                    step_next  = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next  = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_BITS-1]};
                bin_next  = {bin_reg[VALUE_BITS-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(VALUE_BITS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (push_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state resets; datapath holds
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        step_reg <= step_next;
    end

endmodule

[sv/bdac_queue.sv]
// Two-entry queue of converted numbers between converter and emitter.
// Depends on bdac_pkg.
module bdac_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  bdac_pkg::entry_t push_entry,
    output logic             pop_valid,
    input  logic             pop_ready,
    output bdac_pkg::entry_t pop_entry
);
    import bdac_pkg::*;

    entry_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign push_ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_entry  = mem_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and fill count
    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
        if (do_push) begin
            mem_reg[wptr_reg] <= push_entry;
        end
    end

endmodule

[sv/bdac_back.sv]
// Back end: emits the digits of one converted number as ASCII, MSD first.
// Depends on bdac_pkg; takes entries from bdac_queue.
module bdac_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  bdac_pkg::entry_t               pop_entry,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bdac_pkg::M_TDATA_W-1:0] m_tdata,   // [5:0] digit_char
    output logic                           m_tlast    // last
);
    import bdac_pkg::*;

    logic                 busy_reg, busy_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 tvalid_reg, tvalid_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;
    logic                 advance;
    logic [DIGIT_W-1:0]   digit;

    // Output register is free when empty or being drained
    assign advance   = !tvalid_reg || m_tready;
    assign pop_ready = !busy_reg;
    assign digit     = bcd_reg[idx_reg*DIGIT_W +: DIGIT_W];

    assign m_tvalid  = tvalid_reg;
    assign m_tdata   = M_TDATA_W'(char_reg);
    assign m_tlast   = last_reg;

    // Load a number, then step down through its digits
    always_comb begin
        busy_next   = busy_reg;
        bcd_next    = bcd_reg;
        idx_next    = idx_reg;
        tvalid_next = tvalid_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        if (advance) begin
            tvalid_next = busy_reg;
            if (busy_reg) begin
                char_next = ASCII_ZERO | CHAR_W'(digit);
                last_next = (idx_reg == '0);
                if (idx_reg == '0) begin
                    busy_next = 1'b0;
                end else begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
        end
        if (!busy_reg && pop_valid) begin
            busy_next = 1'b1;
            bcd_next  = pop_entry.bcd;
            idx_next  = IDX_W'(pop_entry.ndig - CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            tvalid_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            tvalid_reg <= tvalid_next;
        end
        bcd_reg  <= bcd_next;
        idx_reg  <= idx_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

[sv/binary_to_decimal_ascii_unit.sv]
// Top level of the binary to decimal ASCII unit: converter, queue, emitter.
// Depends on bdac_pkg, bdac_front, bdac_queue and bdac_back.
//
//  Channel | Direction | Carries
//  s_      | in        | tdata[15:0] value (unsigned number)
//  m_      | out       | tdata[5:0] digit_char (ASCII), tlast on least significant digit
//
// A number is taken, then converted by shift-add-3, one step per value bit; the
// converter is ready again after handing its result on, once the queue has room.
// Digits leave one per cycle while m_tready allows, one to five per number,
// from a registered output, with a gap between numbers as the next entry loads.
// Reset (aresetn low at a clock edge) empties the queue and all valid flags.
// A stalled output fills the two-entry queue, then holds the converter and s_tready.
module binary_to_decimal_ascii_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bdac_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] value
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bdac_pkg::M_TDATA_W-1:0] m_tdata,   // [5:0] digit_char
    output logic                           m_tlast    // last
);
    import bdac_pkg::*;

    logic   push_valid, push_ready, pop_valid, pop_ready;
    entry_t push_entry, pop_entry;

    bdac_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    bdac_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    bdac_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[tb/tb.sv]
// Testbench for binary_to_decimal_ascii_unit: random and directed numbers in,
// ASCII digit stream checked against a local predictor. Depends on bdac_pkg and the RTL.
module tb;
    import bdac_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int RANDOM_COUNT  = 400;
    localparam int IDLE_PERCENT  = 37;
    localparam int DRAIN_CYCLES  = 40;

    // One expected output character
    typedef struct {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
    } char_t;

    // Predict the digit string of each accepted number and check the output
    class digit_scoreboard;
        char_t expected_chars[$];
        int    errors;
        int    numbers;
        int    chars;
        int    by_length[6];

        function new();
            errors  = 0;
            numbers = 0;
            chars   = 0;
            foreach (by_length[i]) by_length[i] = 0;
        endfunction

        // Split the number into decimal digits, queue them most significant first
        function void note_number(logic [VALUE_BITS-1:0] value);
            logic [3:0]            digits[10];
            logic [VALUE_BITS-1:0] rest;
            int                    count;
            char_t                 c;
            rest  = value;
            count = 0;
            if (rest == '0) begin
                digits[0] = 4'd0;
                count     = 1;
            end else begin
                while (rest != '0) begin
                    digits[count] = 4'(rest % 10);
                    rest          = rest / 10;
                    count++;
                end
            end
            for (int k = count - 1; k >= 0; k--) begin
                c.digit_char = ASCII_ZERO + CHAR_W'(digits[k]);
                c.last       = (k == 0);
                expected_chars.push_back(c);
            end
            numbers++;
            by_length[count]++;
        endfunction

        // Compare one output transfer with the oldest expected character
        function void check_char(logic [CHAR_W-1:0] digit_char, logic last);
            char_t exp_c;
            chars++;
            if (expected_chars.size() == 0) begin
                $error("unexpected output: digit_char=%0d last=%0b", digit_char, last);
                errors++;
                return;
            end
            exp_c = expected_chars.pop_front();
            if (digit_char !== exp_c.digit_char) begin
                $error("digit_char: expected %0d, actual %0d", exp_c.digit_char, digit_char);
                errors++;
            end
            if (last !== exp_c.last) begin
                $error("last: expected %0b, actual %0b", exp_c.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    digit_scoreboard board = new();
    bit              calm  = 1'b0;
    int              cycles = 0;

    binary_to_decimal_ascii_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // [15:0] value
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),     // [5:0] digit_char
        .m_tlast  (m_tlast)      // last
    );

    always #2 aclk = ~aclk;

    // Stop a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d characters still expected",
                     cycles, board.pending());
            $display("status: fail");
            $finish;
        end
    end

    // Check each output transfer, then pick the next ready value
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_char(m_tdata[CHAR_W-1:0], m_tlast);
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Offer one number, idling at random first, and hold it until the transfer
    task automatic send_number(input logic [VALUE_BITS-1:0] value);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(value);
        do @(posedge aclk); while (!s_tready);
        board.note_number(value);
    endtask

    // Draw a number, half the time spread over the digit counts, else over all bits
    function automatic logic [VALUE_BITS-1:0] random_number();
        if ($urandom_range(0, 1) == 0) begin
            return VALUE_BITS'($urandom);
        end
        case ($urandom_range(1, 5))
            1: return VALUE_BITS'($urandom_range(0, 9));
            2: return VALUE_BITS'($urandom_range(10, 99));
            3: return VALUE_BITS'($urandom_range(100, 999));
            4: return VALUE_BITS'($urandom_range(1000, 9999));
            default: return VALUE_BITS'($urandom_range(10000, 65535));
        endcase
    endfunction

    initial begin
        logic [VALUE_BITS-1:0] directed[$];
        int                    wait_cycles;

        // Hold reset low, then release it
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero, the maximum, digit-count boundaries and alternating bit patterns
        directed = '{16'd0, 16'd65535, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999,
                     16'd1000, 16'd9999, 16'd10000, 16'd65534, 16'h5555, 16'hAAAA,
                     16'h8000, 16'd12345, 16'd60000, 16'd50005, 16'd10001, 16'd90,
                     16'd0, 16'd7};
        foreach (directed[i]) send_number(directed[i]);

        // Random numbers, with a stretch in the middle where neither side idles
        for (int n = 0; n < RANDOM_COUNT; n++) begin
            calm <= (n >= 200 && n < 280);
            send_number(random_number());
        end
        s_tvalid <= 1'b0;
        calm     <= 1'b0;

        // Drain the expected digits, then watch for stray output
        while (board.pending() != 0) @(posedge aclk);
        wait_cycles = 0;
        while (wait_cycles < DRAIN_CYCLES) begin
            @(posedge aclk);
            wait_cycles++;
        end

        $display("converted %0d numbers into %0d characters in %0d cycles",
                 board.numbers, board.chars, cycles);
        $display("numbers by digit count 1..5: %0d %0d %0d %0d %0d", board.by_length[1],
                 board.by_length[2], board.by_length[3], board.by_length[4], board.by_length[5]);
        if (board.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
